// ----- rtl/ffha_pkg.sv -----
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int AddrW   = 48;
  localparam int PagesW  = 5;
  localparam int SizeW   = 13;
  localparam int PageGr  = 256;
  localparam int GranLog = 4;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  localparam logic       REG_BASE  = 1'b0;
  localparam logic       REG_PAGES = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0]  base;
    logic [PagesW-1:0] pages;
    logic              init;
  } cfg_t;

endpackage

// ----- rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator top level.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  operation, request_size, release_address
//   out_     output     out_valid/ready    granted_address, status
//   cfg      APB        psel/penable       heap_base (0x0), heap_pages (0x8)
//
// One item at a time. An allocate walks the segment headers from the first one
// until a free segment fits, and writes a new header when it splits; a free
// takes the same walk up to its segment, then merges with free neighbours.
// Each step is one segment store read. After reset the first header is rewritten;
// a register write holds the input off while it does the same.
// The result register lets the walk of the next item start while a result waits.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [15:0]                 in_request_size,
  input  logic [ffha_pkg::AddrW-1:0]  in_release_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ffha_pkg::AddrW-1:0]  out_granted_address,
  output logic [1:0]                  out_status
);
  import ffha_pkg::*;

  cfg_t cfg;

  ffha_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffha_ctrl #(.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_request_size     (in_request_size),
    .in_release_address  (in_release_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

endmodule

// ----- rtl/ffha_cfg.sv -----
// APB configuration registers: heap base and page count.
module ffha_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output ffha_pkg::cfg_t     cfg
);
  import ffha_pkg::*;

  logic [AddrW-1:0]  base_r;
  logic [PagesW-1:0] pages_r;
  logic              init_r;
  logic              wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      pages_r <= PagesW'(16);
      init_r  <= 1'b0;
    end else begin
      init_r <= wr;
      if (wr) begin
        if (paddr[3] == REG_BASE) begin
          base_r <= pwdata[AddrW-1:0];
        end else begin
          pages_r <= pwdata[PagesW-1:0];
        end
      end
    end
  end

  always_comb begin
    if (paddr[3] == REG_PAGES) begin
      prdata = {{(64-PagesW){1'b0}}, pages_r};
    end else begin
      prdata = {{(64-AddrW){1'b0}}, base_r};
    end
  end

  assign cfg.base  = base_r;
  assign cfg.pages = pages_r;
  assign cfg.init  = init_r || wr;

endmodule

// ----- rtl/ffha_seg_store.sv -----
// Segment header store: length/free memory and previous-link memory.
module ffha_seg_store #(
  parameter int DEPTH = 4096,
  parameter int GW    = 12,
  parameter int LW    = 13
) (
  input  logic          clk,
  input  logic [GW-1:0] rd_addr,
  output logic [LW-1:0] rd_len,
  output logic          rd_free,
  output logic [GW-1:0] rd_prev,
  input  logic          a_we,
  input  logic [GW-1:0] a_waddr,
  input  logic [LW-1:0] a_wlen,
  input  logic          a_wfree,
  input  logic          p_we,
  input  logic [GW-1:0] p_waddr,
  input  logic [GW-1:0] p_wprev
);

  logic [LW:0]   mem_a [DEPTH];
  logic [GW-1:0] mem_p [DEPTH];
  logic [LW:0]   a_q_r;
  logic [GW-1:0] p_q_r;

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[a_waddr] <= {a_wfree, a_wlen};
    end
    a_q_r <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      mem_p[p_waddr] <= p_wprev;
    end
    p_q_r <= mem_p[rd_addr];
  end

  assign rd_free = a_q_r[LW];
  assign rd_len  = a_q_r[LW-1:0];
  assign rd_prev = p_q_r;

endmodule

// ----- rtl/ffha_ctrl.sv -----
// Allocation and release sequencer: walks, splits and merges segments.
module ffha_ctrl #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffha_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [15:0]                  in_request_size,
  input  logic [ffha_pkg::AddrW-1:0]   in_release_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ffha_pkg::AddrW-1:0]   out_granted_address,
  output logic [1:0]                   out_status
);
  import ffha_pkg::*;

  localparam int SLOTS    = HEAP_BYTES / 16;
  localparam int HDR_GR   = (HEADER_BYTES + 15) / 16;
  localparam int HDR_SPAN = HDR_GR * 16;
  localparam int MAXP     = HEAP_BYTES / 4096;
  localparam int GW       = $clog2(SLOTS);
  localparam int LW       = $clog2(SLOTS + 1);
  localparam int NW       = LW + 2;
  localparam int CW       = LW + SizeW + 1;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ACHK = 4'd2;
  localparam logic [3:0] S_AWN  = 4'd3;
  localparam logic [3:0] S_FCHK = 4'd4;
  localparam logic [3:0] S_MST  = 4'd5;
  localparam logic [3:0] S_MCHK = 4'd6;
  localparam logic [3:0] S_MDON = 4'd7;
  localparam logic [3:0] S_MPV  = 4'd8;
  localparam logic [3:0] S_MPVC = 4'd9;
  localparam logic [3:0] S_RESP = 4'd10;

  function automatic logic [GW-1:0] next_of(logic [GW-1:0] s, logic [LW-1:0] len);
    logic [NW-1:0] sum;
    sum = NW'(s) + NW'(HDR_GR) + NW'(len);
    return (sum < NW'(SLOTS)) ? sum[GW-1:0] : '0;
  endfunction

  logic [3:0]       state_r, state_nxt;
  logic [GW-1:0]    cur_r, cur_nxt;
  logic [GW-1:0]    tgt_r, tgt_nxt;
  logic [GW-1:0]    last_r, last_nxt;
  logic [GW-1:0]    mtgt_r, mtgt_nxt;
  logic [LW-1:0]    mlen_r, mlen_nxt;
  logic [GW-1:0]    nx_r, nx_nxt;
  logic             phase_r, phase_nxt;
  logic [SizeW-1:0] size_r, size_nxt;
  logic [GW-1:0]    nseg_r, nseg_nxt;
  logic [LW-1:0]    rem_r, rem_nxt;
  logic [AddrW-1:0] res_addr_r, res_addr_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [AddrW-1:0] out_addr_r, out_addr_nxt;
  logic [1:0]       out_st_r, out_st_nxt;

  logic [GW-1:0]    rd_addr;
  logic [LW-1:0]    rd_len;
  logic             rd_free;
  logic [GW-1:0]    rd_prev;
  logic             a_we, a_wfree, p_we;
  logic [GW-1:0]    a_waddr, p_waddr, p_wprev;
  logic [LW-1:0]    a_wlen;

  logic [16:0]      size_sum;
  logic [AddrW-1:0] off, off2;
  logic             accept;
  logic [PagesW:0]  pc;
  logic [LW-1:0]    len0;
  logic [GW-1:0]    n_seg, pv;

  ffha_seg_store #(.DEPTH(SLOTS), .GW(GW), .LW(LW)) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_len  (rd_len),
    .rd_free (rd_free),
    .rd_prev (rd_prev),
    .a_we    (a_we),
    .a_waddr (a_waddr),
    .a_wlen  (a_wlen),
    .a_wfree (a_wfree),
    .p_we    (p_we),
    .p_waddr (p_waddr),
    .p_wprev (p_wprev)
  );

  assign in_ready            = (state_r == S_IDLE) && !cfg.init;
  assign accept              = in_valid && in_ready;
  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_st_r;

  assign size_sum = 17'(in_request_size) + 17'd15;
  assign off      = in_release_address - cfg.base;
  assign off2     = off - AddrW'(HDR_SPAN);
  assign n_seg    = next_of(cur_r, LW'(size_r));
  assign pv       = (int'(rd_prev) < SLOTS) ? rd_prev : '0;

  always_comb begin
    if (cfg.pages == '0) begin
      pc = (PagesW+1)'(1);
    end else if (int'(cfg.pages) > MAXP) begin
      pc = (PagesW+1)'(MAXP);
    end else begin
      pc = (PagesW+1)'(cfg.pages);
    end
    len0 = LW'(int'(pc) * PageGr - HDR_GR);
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    last_nxt      = last_r;
    mtgt_nxt      = mtgt_r;
    mlen_nxt      = mlen_r;
    nx_nxt        = nx_r;
    phase_nxt     = phase_r;
    size_nxt      = size_r;
    nseg_nxt      = nseg_r;
    rem_nxt       = rem_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    rd_addr       = cur_r;
    a_we          = 1'b0;
    a_waddr       = cur_r;
    a_wlen        = rd_len;
    a_wfree       = 1'b0;
    p_we          = 1'b0;
    p_waddr       = cur_r;
    p_wprev       = cur_r;

    case (state_r)
      S_INIT: begin
        a_we      = 1'b1;
        a_waddr   = '0;
        a_wlen    = len0;
        a_wfree   = 1'b1;
        p_we      = 1'b1;
        p_waddr   = '0;
        p_wprev   = '0;
        last_nxt  = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_OK;
          cur_nxt      = '0;
          rd_addr      = '0;
          if (in_operation == OP_ALLOC) begin
            size_nxt = size_sum[16:GranLog];
            if (in_request_size == '0) begin
              res_st_nxt = ST_ZERO;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_ACHK;
            end
          end else begin
            tgt_nxt = off2[GW+GranLog-1:GranLog];
            if (off < AddrW'(HDR_SPAN) || off2[GranLog-1:0] != '0 ||
                (off2 >> GranLog) >= AddrW'(SLOTS)) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_FCHK;
            end
          end
        end
      end
      S_ACHK: begin
        if (rd_free && CW'(rd_len) >= CW'(size_r)) begin
          res_addr_nxt = cfg.base + AddrW'({cur_r, 4'b0}) + AddrW'(HDR_SPAN);
          res_st_nxt   = ST_OK;
          a_we         = 1'b1;
          a_wfree      = 1'b0;
          if (CW'(rd_len) >= CW'(size_r) + CW'(HDR_GR + 1)) begin
            a_wlen   = LW'(size_r);
            nseg_nxt = n_seg;
            rem_nxt  = rd_len - LW'(size_r) - LW'(HDR_GR);
            if (cur_r != last_r) begin
              p_we    = 1'b1;
              p_waddr = next_of(cur_r, rd_len);
              p_wprev = n_seg;
            end else begin
              last_nxt = n_seg;
            end
            state_nxt = S_AWN;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (cur_r == last_r) begin
          res_st_nxt = ST_NOFIT;
          state_nxt  = S_RESP;
        end else begin
          cur_nxt = next_of(cur_r, rd_len);
          rd_addr = cur_nxt;
        end
      end
      S_AWN: begin
        a_we      = 1'b1;
        a_waddr   = nseg_r;
        a_wlen    = rem_r;
        a_wfree   = 1'b1;
        p_we      = 1'b1;
        p_waddr   = nseg_r;
        p_wprev   = cur_r;
        state_nxt = S_RESP;
      end
      S_FCHK: begin
        if (cur_r == tgt_r) begin
          a_we      = 1'b1;
          a_wfree   = 1'b1;
          mtgt_nxt  = cur_r;
          mlen_nxt  = rd_len;
          phase_nxt = 1'b0;
          state_nxt = S_MST;
        end else if (cur_r == last_r || cur_r > tgt_r) begin
          state_nxt = S_RESP;
        end else begin
          cur_nxt = next_of(cur_r, rd_len);
          rd_addr = cur_nxt;
        end
      end
      S_MST: begin
        if (mtgt_r == last_r) begin
          state_nxt = S_MDON;
        end else begin
          nx_nxt    = next_of(mtgt_r, mlen_r);
          rd_addr   = nx_nxt;
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (rd_free) begin
          if (nx_r == last_r) begin
            last_nxt = mtgt_r;
          end else begin
            p_we    = 1'b1;
            p_waddr = next_of(nx_r, rd_len);
            p_wprev = mtgt_r;
          end
          a_we    = 1'b1;
          a_waddr = mtgt_r;
          a_wlen  = mlen_r + rd_len + LW'(HDR_GR);
          a_wfree = 1'b1;
        end
        state_nxt = S_MDON;
      end
      S_MDON: begin
        if (phase_r || cur_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          rd_addr   = cur_r;
          state_nxt = S_MPV;
        end
      end
      S_MPV: begin
        nx_nxt    = pv;
        rd_addr   = pv;
        state_nxt = S_MPVC;
      end
      S_MPVC: begin
        if (rd_free) begin
          mtgt_nxt  = nx_r;
          mlen_nxt  = rd_len;
          phase_nxt = 1'b1;
          state_nxt = S_MST;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    if (cfg.init) begin
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      last_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    tgt_r      <= tgt_nxt;
    mtgt_r     <= mtgt_nxt;
    mlen_r     <= mlen_nxt;
    nx_r       <= nx_nxt;
    size_r     <= size_nxt;
    nseg_r     <= nseg_nxt;
    rem_r      <= rem_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
  end

endmodule

// ----- dv/ffha_checker.sv -----
// Checker for the first-fit heap allocator: mirrors the heap and compares every result.
module ffha_checker #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [63:0]                pwdata,
  input  logic                       pready,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_operation,
  input  logic [15:0]                in_request_size,
  input  logic [ffha_pkg::AddrW-1:0] in_release_address,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ffha_pkg::AddrW-1:0] out_granted_address,
  input  logic [1:0]                 out_status,
  output int                         errors,
  output int                         backlog
);
  import ffha_pkg::*;

  localparam int unsigned SLOTS    = HEAP_BYTES / 16;
  localparam int unsigned HDR_GR   = (HEADER_BYTES + 15) / 16;
  localparam int unsigned HDR_SPAN = HDR_GR * 16;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [1:0]       status;
  } grant_t;

  int unsigned      seg_len  [SLOTS];
  bit               seg_free [SLOTS];
  int unsigned      seg_prev [SLOTS];
  int unsigned      last_seg;
  logic [AddrW-1:0] heap_base;
  logic [4:0]       heap_pages;
  grant_t           grants_due[$];

  function int unsigned wrap_slot(int unsigned g);
    return (g < SLOTS) ? g : 0;
  endfunction

  function int unsigned next_seg(int unsigned s);
    return wrap_slot(s + HDR_GR + seg_len[s] / 16);
  endfunction

  function void heap_reset();
    int unsigned pg;
    pg = {27'd0, heap_pages};
    if (pg == 0) pg = 1;
    if (pg > HEAP_BYTES / 4096) pg = HEAP_BYTES / 4096;
    for (int i = 0; i < SLOTS; i++) begin
      seg_len[i]  = 0;
      seg_free[i] = 0;
      seg_prev[i] = 0;
    end
    seg_len[0]  = pg * 4096 - HDR_SPAN;
    seg_free[0] = 1;
    last_seg    = 0;
  endfunction

  function void absorb_next(int unsigned s);
    int unsigned nx;
    if (s == last_seg) return;
    nx = next_seg(s);
    if (!seg_free[nx]) return;
    if (nx == last_seg) last_seg = s;
    else seg_prev[next_seg(nx)] = s;
    seg_len[s] = seg_len[s] + seg_len[nx] + HDR_SPAN;
  endfunction

  function void absorb_previous(int unsigned s);
    int unsigned pv;
    if (s == 0) return;
    pv = wrap_slot(seg_prev[s]);
    if (seg_free[pv]) absorb_next(pv);
  endfunction

  function void carve(int unsigned s, int unsigned size);
    int unsigned len, n;
    len = seg_len[s];
    if (len < size + HDR_SPAN + 16) return;
    n = wrap_slot(s + HDR_GR + size / 16);
    if (s != last_seg) seg_prev[next_seg(s)] = n;
    seg_prev[n] = s;
    seg_len[n]  = len - size - HDR_SPAN;
    seg_free[n] = seg_free[s];
    seg_len[s]  = size;
    if (last_seg == s) last_seg = n;
  endfunction

  function grant_t grant(int unsigned size);
    int unsigned s;
    grant_t g;
    s = 0;
    g.addr   = '0;
    g.status = ST_NOFIT;
    for (int unsigned k = 0; k <= SLOTS; k++) begin
      if (seg_free[s] && seg_len[s] >= size) begin
        carve(s, size);
        seg_free[s] = 0;
        g.addr   = heap_base + AddrW'(s * 16 + HDR_SPAN);
        g.status = ST_OK;
        return g;
      end
      if (s == last_seg) break;
      s = next_seg(s);
    end
    return g;
  endfunction

  function void give_back(logic [AddrW-1:0] address);
    logic [AddrW-1:0] off;
    int unsigned t, s;
    off = address - heap_base;
    if (off < HDR_SPAN) return;
    off = off - HDR_SPAN;
    if (off[3:0] != 0) return;
    if ((off >> 4) >= SLOTS) return;
    t = 32'(off >> 4);
    s = 0;
    for (int unsigned k = 0; k <= SLOTS; k++) begin
      if (s == t) begin
        seg_free[s] = 1;
        absorb_next(s);
        absorb_previous(s);
        return;
      end
      if (s == last_seg || s > t) return;
      s = next_seg(s);
    end
  endfunction

  function grant_t predict(logic op, logic [15:0] req, logic [AddrW-1:0] rel);
    grant_t g;
    g = '0;
    if (op == OP_ALLOC) begin
      if (req == 0) g.status = ST_ZERO;
      else g = grant((int'(req) + 15) & ~15);
    end else begin
      give_back(rel);
    end
    return g;
  endfunction

  assign backlog = grants_due.size();

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      errors     = 0;
      heap_base  = '0;
      heap_pages = 5'd16;
      heap_reset();
      grants_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
        if (paddr[3] == REG_BASE) heap_base = pwdata[AddrW-1:0];
        else heap_pages = pwdata[4:0];
        heap_reset();
      end
      if (in_valid && in_ready)
        grants_due.push_back(predict(in_operation, in_request_size, in_release_address));
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transaction: addr %h status %0d",
                     out_granted_address, out_status);
        end else begin
          want = grants_due.pop_front();
          if (want.addr !== out_granted_address || want.status !== out_status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                       want.addr, want.status, out_granted_address, out_status);
          end
        end
      end
    end
  end

endmodule

// ----- dv/first_fit_heap_allocator_test.sv -----
// Top of the heap allocator testbench: clock, reset, stimulus and verdict.
module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  localparam int WATCH_LIMIT = 40000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [63:0]      pwdata = '0;
  logic [63:0]      prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_operation = OP_ALLOC;
  logic [15:0]      in_request_size = '0;
  logic [AddrW-1:0] in_release_address = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [AddrW-1:0] out_granted_address;
  logic [1:0]       out_status;

  int               errors, backlog;
  logic             in_fire = 1'b0;
  int               sent = 0, got = 0, idle_cycles = 0;
  bit               calm = 0, hold_ask = 0;
  int               hold_cnt = 0, stall_cnt = 0;
  logic [AddrW-1:0] live[$];
  logic [AddrW-1:0] freed[$];
  logic [AddrW-1:0] cur_base;

  first_fit_heap_allocator dut (.*);

  ffha_checker checker_i (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (out_valid && out_ready) begin
      got <= got + 1;
      if (out_status == ST_OK && out_granted_address != 0) live.push_back(out_granted_address);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_ask && hold_cnt == 0) begin
      hold_ask = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_cnt = $urandom_range(0, 16);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic send(logic op, logic [15:0] req, logic [AddrW-1:0] rel);
    in_valid           = 1'b1;
    in_operation       = op;
    in_request_size    = req;
    in_release_address = rel;
    do @(negedge clk); while (!in_fire);
    sent++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (got != sent) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(logic reg_sel, logic [63:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {reg_sel, 3'b000};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic setup_heap(logic [AddrW-1:0] base, logic [4:0] pages);
    drain();
    live.delete();
    freed.delete();
    reg_write(REG_PAGES, {$urandom, 27'd0, pages});
    reg_write(REG_BASE, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | 64'(base));
    cur_base = base;
    repeat (3) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    int k;
    logic [15:0] req;
    r = $urandom_range(0, 99);
    if (r < 50 || (live.size() == 0 && r < 85)) begin
      r = $urandom_range(0, 99);
      if (r < 3) req = 0;
      else if (r < 70) req = 16'($urandom_range(1, 256));
      else if (r < 90) req = 16'($urandom_range(1, 2048));
      else if (r < 97) req = 16'($urandom_range(1, 16384));
      else req = 16'($urandom);
      send(OP_ALLOC, req, AddrW'({$urandom, $urandom}));
    end else if (live.size() > 0 && r < 90) begin
      k = $urandom_range(0, live.size() - 1);
      freed.push_back(live[k]);
      send(OP_FREE, 16'($urandom), live[k]);
      live.delete(k);
    end else if (freed.size() > 0 && r < 94) begin
      send(OP_FREE, 16'($urandom), freed[$urandom_range(0, freed.size() - 1)]);
    end else if (r < 97) begin
      send(OP_FREE, 16'($urandom), cur_base + AddrW'($urandom_range(0, 70000)));
    end else begin
      send(OP_FREE, 16'($urandom), AddrW'({$urandom, $urandom}));
    end
  endtask

  initial begin
    logic [AddrW-1:0] bases[5];
    logic [4:0]       pages[5];
    bases[0] = '0;                            pages[0] = 5'd16;
    bases[1] = 48'hFFFF_FFFF_F800;            pages[1] = 5'd1;
    bases[2] = AddrW'({$urandom, $urandom});  pages[2] = 5'd0;
    bases[3] = 48'hFFFF_FFFF_FFFF;            pages[3] = 5'd31;
    bases[4] = AddrW'({$urandom, $urandom});  pages[4] = 5'($urandom_range(1, 16));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    setup_heap(48'h0, 5'd16);

    // fresh heap at base 0: split chain, frees with merging, whole-heap grants
    send(OP_ALLOC, 16'd0, '0);
    send(OP_ALLOC, 16'd1, '0);
    send(OP_ALLOC, 16'd16, '0);
    send(OP_ALLOC, 16'd17, '0);
    send(OP_ALLOC, 16'hFFFF, '0);
    send(OP_FREE, '0, 48'd80);
    send(OP_FREE, '0, 48'd32);
    send(OP_FREE, '0, 48'd32);
    send(OP_FREE, '0, 48'd33);
    send(OP_FREE, '0, 48'd16);
    send(OP_FREE, '0, 48'hFFFF_FFFF_FFFF);
    send(OP_FREE, '0, 48'd128);
    send(OP_ALLOC, 16'd65504, '0);
    send(OP_ALLOC, 16'd1, '0);
    send(OP_FREE, '0, 48'd32);
    send(OP_ALLOC, 16'd65480, '0);
    send(OP_FREE, '0, 48'd32);

    for (int ph = 0; ph < 5; ph++) begin
      setup_heap(bases[ph], pages[ph]);
      for (int i = 0; i < 105; i++) begin
        if (ph == 4 && i > 50) calm = 1;
        if (ph == 1 && i == 40) hold_ask = 1;
        if (i == 60) begin
          in_valid = 1'b0;
          while (got != sent) @(negedge clk);
        end
        if (!calm && $urandom_range(0, 7) == 0) begin
          in_valid = 1'b0;
          repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        random_item();
      end
    end

    drain();
    repeat (30) @(negedge clk);
    if (errors == 0 && backlog == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
